[design/c2p_pkg.sv]
// Package for the Cartesian-to-polar converter: payload and pipeline types,
// fixed-point constants and the arctangent table. No dependencies.
`timescale 1ns / 1ps

package c2p_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int GUARD_BITS   = 16;
  // x/y grow by the CORDIC gain (< 2) on top of a full-scale pre-rotation
  localparam int XY_W         = SAMPLE_WIDTH + GUARD_BITS + 3;
  // angle accumulator counts 2^-20 degree
  localparam int Z_W          = 30;
  localparam int SUM_W        = 2 * SAMPLE_WIDTH;
  localparam int ROOT_STEPS   = SAMPLE_WIDTH;
  localparam int TABLE_LEN    = 32;
  localparam int PHASE_SHIFT  = 13;
  localparam int PHASE_W      = Z_W - PHASE_SHIFT;
  localparam int ROUND_HALF   = 4096;
  localparam int ANGLE_90     = 94371840;
  localparam int PHASE_180    = 23040;
  localparam int PHASE_90     = 11520;
  localparam int MAG_MAX      = 65535;

  typedef struct packed {
    logic signed [15:0] real_part;
    logic signed [15:0] imag_part;
  } c2p_in_t;

  typedef struct packed {
    logic        [15:0] magnitude;
    logic signed [15:0] phase_degrees;
  } c2p_out_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [SUM_W-1:0]       rem;
    logic [SUM_W-1:0]       root;
    logic                   ovr;
    logic signed [15:0]     ovr_phase;
  } c2p_work_t;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned idx);
    int val;
    case (idx)
      0:  val = 47185920;
      1:  val = 27855475;
      2:  val = 14718068;
      3:  val = 7471121;
      4:  val = 3750058;
      5:  val = 1876857;
      6:  val = 938658;
      7:  val = 469357;
      8:  val = 234682;
      9:  val = 117342;
      10: val = 58671;
      11: val = 29335;
      12: val = 14668;
      13: val = 7334;
      14: val = 3667;
      15: val = 1833;
      16: val = 917;
      17: val = 458;
      18: val = 229;
      19: val = 115;
      20: val = 57;
      21: val = 29;
      22: val = 14;
      23: val = 7;
      24: val = 4;
      25: val = 2;
      26: val = 1;
      default: val = 0;
    endcase
    return Z_W'(val);
  endfunction

endpackage

[design/c2p_front.sv]
// Input stage: squares for the magnitude, quadrant pre-rotation for the
// CORDIC and detection of the exact-angle cases. Depends on c2p_pkg.
`timescale 1ns / 1ps

module c2p_front import c2p_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  c2p_in_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output c2p_work_t out_work
);

  logic signed [SAMPLE_WIDTH-1:0] re;
  logic signed [SAMPLE_WIDTH-1:0] im;
  logic signed [SAMPLE_WIDTH:0]   re_neg;
  logic signed [SAMPLE_WIDTH:0]   im_neg;
  logic [SAMPLE_WIDTH-1:0]        abs_re;
  logic [SAMPLE_WIDTH-1:0]        abs_im;
  logic [SUM_W-1:0]               sq_re;
  logic [SUM_W-1:0]               sq_im;
  logic signed [XY_W-1:0]         x0;
  logic signed [XY_W-1:0]         y0;
  logic                           re_zero;
  logic                           im_zero;
  c2p_work_t                      work_next;

  always_comb begin
    re      = in_data.real_part;
    im      = in_data.imag_part;
    re_neg  = -{re[SAMPLE_WIDTH-1], re};
    im_neg  = -{im[SAMPLE_WIDTH-1], im};
    abs_re  = re[SAMPLE_WIDTH-1] ? re_neg[SAMPLE_WIDTH-1:0] : re;
    abs_im  = im[SAMPLE_WIDTH-1] ? im_neg[SAMPLE_WIDTH-1:0] : im;
    sq_re   = abs_re * abs_re;
    sq_im   = abs_im * abs_im;
    x0      = {{(XY_W-SAMPLE_WIDTH-GUARD_BITS){re[SAMPLE_WIDTH-1]}}, re,
               {GUARD_BITS{1'b0}}};
    y0      = {{(XY_W-SAMPLE_WIDTH-GUARD_BITS){im[SAMPLE_WIDTH-1]}}, im,
               {GUARD_BITS{1'b0}}};
    re_zero = (re == '0);
    im_zero = (im == '0);

    work_next.rem  = sq_re + sq_im;
    work_next.root = '0;

    // fold the left half-plane into the right one
    if (re[SAMPLE_WIDTH-1] && !im[SAMPLE_WIDTH-1]) begin
      work_next.x = y0;
      work_next.y = -x0;
      work_next.z = Z_W'(ANGLE_90);
    end else if (re[SAMPLE_WIDTH-1]) begin
      work_next.x = -y0;
      work_next.y = x0;
      work_next.z = -(Z_W'(ANGLE_90));
    end else begin
      work_next.x = x0;
      work_next.y = y0;
      work_next.z = '0;
    end

    work_next.ovr       = re_zero || im_zero;
    work_next.ovr_phase = '0;
    if (re_zero && im_zero) begin
      work_next.ovr_phase = '0;
    end else if (im_zero) begin
      work_next.ovr_phase = re[SAMPLE_WIDTH-1] ? 16'(PHASE_180) : '0;
    end else if (re_zero) begin
      work_next.ovr_phase = im[SAMPLE_WIDTH-1] ? -(16'(PHASE_90)) : 16'(PHASE_90);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_work <= work_next;
    end
  end

endmodule

[design/c2p_stage.sv]
// One pipeline step: a CORDIC micro-rotation by atan(2^-K) if K < ITERATIONS
// and a restoring square-root result bit if K < ROOT_STEPS. Depends on c2p_pkg.
`timescale 1ns / 1ps

module c2p_stage import c2p_pkg::*; #(
  parameter int K          = 0,
  parameter int ITERATIONS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  c2p_work_t in_work,
  output logic      out_valid,
  input  logic      out_ready,
  output c2p_work_t out_work
);

  localparam bit ROTATE  = (K < ITERATIONS);
  localparam bit ROOT_EN = (K < ROOT_STEPS);
  localparam int BIT_POS = ROOT_EN ? (SUM_W - 2 - 2 * K) : 0;
  localparam logic [SUM_W:0] ROOT_BIT = (SUM_W+1)'(1) << BIT_POS;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  da;
  logic [SUM_W:0]         trial;
  c2p_work_t              work_next;

  always_comb begin
    work_next = in_work;
    dx        = in_work.y >>> K;
    dy        = in_work.x >>> K;
    da        = atan_entry(K);
    trial     = {1'b0, in_work.root} + ROOT_BIT;

    if (ROTATE) begin
      // rotate toward the x axis, both updates from the old x and y
      if (!in_work.y[XY_W-1]) begin
        work_next.x = in_work.x + dx;
        work_next.y = in_work.y - dy;
        work_next.z = in_work.z + da;
      end else begin
        work_next.x = in_work.x - dx;
        work_next.y = in_work.y + dy;
        work_next.z = in_work.z - da;
      end
    end

    if (ROOT_EN) begin
      if ({1'b0, in_work.rem} >= trial) begin
        work_next.rem  = in_work.rem - trial[SUM_W-1:0];
        work_next.root = (in_work.root >> 1) + ROOT_BIT[SUM_W-1:0];
      end else begin
        work_next.root = in_work.root >> 1;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_work <= work_next;
    end
  end

endmodule

[design/c2p_back.sv]
// Output stage: round the root to nearest, scale and clamp the angle, apply
// the exact-angle cases. Holds the result register. Depends on c2p_pkg.
`timescale 1ns / 1ps

module c2p_back import c2p_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  c2p_work_t in_work,
  output logic      out_valid,
  input  logic      out_ready,
  output c2p_out_t  out_data
);

  logic [SUM_W-1:0]          mag_round;
  logic signed [Z_W-1:0]     z_round;
  logic signed [PHASE_W-1:0] phase_full;
  c2p_out_t                  data_next;

  always_comb begin
    // remainder above the root means the true root is past the half point
    mag_round  = (in_work.rem > in_work.root) ? in_work.root + SUM_W'(1) : in_work.root;
    z_round    = in_work.z + Z_W'(ROUND_HALF);
    phase_full = PHASE_W'(z_round >>> PHASE_SHIFT);

    data_next.magnitude = (mag_round > SUM_W'(MAG_MAX)) ? 16'(MAG_MAX)
                                                        : mag_round[15:0];
    if (in_work.ovr) begin
      data_next.phase_degrees = in_work.ovr_phase;
    end else if (phase_full > PHASE_W'(PHASE_180)) begin
      data_next.phase_degrees = 16'(PHASE_180);
    end else if (phase_full < -(PHASE_W'(PHASE_180))) begin
      data_next.phase_degrees = -(16'(PHASE_180));
    end else begin
      data_next.phase_degrees = phase_full[15:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
  a_load_sets: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("loaded request not presented");
  a_bubble_clears: assert property (@(posedge clk) disable iff (rst)
    !in_valid && in_ready |=> !out_valid)
    else $error("result presented without a request");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.phase_degrees <= 16'sd23040) &&
                  (out_data.phase_degrees >= -16'sd23040))
    else $error("phase outside half-turn range");
`endif

endmodule

[design/cartesian_to_polar.sv]
// Cartesian-to-polar converter: magnitude and four-quadrant phase of a
// complex sample. Depends on c2p_pkg, c2p_front, c2p_stage, c2p_back.
//
// Usage:
//   sample (real_part, imag_part) enters on sample_valid/sample_ready;
//   result (magnitude, phase_degrees) leaves on result_valid/result_ready.
//   magnitude is round(sqrt(re^2 + im^2)); phase_degrees is atan2(im, re)
//   in 1/128 degree, within -180..+180 degrees, 0 when both parts are zero.
// Throughput: one request per cycle while result_ready is high, no gaps between back-to-back requests.
// Stages: one input stage, one per CORDIC micro-rotation or square-root bit,
//   whichever count is larger, and one rounding/output stage.
// Every stage has its own valid bit and loads when it is empty or its
//   successor moves, so bubbles close up while the receiver stalls; the
//   pipeline then fills and sample_ready drops once every stage holds a
//   request. Nothing is dropped or repeated across a stall.
// Reset clears all valid bits; no other state is kept between samples.
`timescale 1ns / 1ps

module cartesian_to_polar import c2p_pkg::*; #(
  parameter int ITERATIONS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     sample_valid,
  output logic     sample_ready,
  input  c2p_in_t  sample,
  output logic     result_valid,
  input  logic     result_ready,
  output c2p_out_t result
);

  localparam int DEPTH = (ITERATIONS > ROOT_STEPS) ? ITERATIONS : ROOT_STEPS;

  c2p_work_t work  [DEPTH+1];
  logic      valid [DEPTH+1];
  logic      ready [DEPTH+1];

  c2p_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_valid),
    .in_ready  (sample_ready),
    .in_data   (sample),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .out_work  (work[0])
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    c2p_stage #(
      .K          (k),
      .ITERATIONS (ITERATIONS)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[k]),
      .in_ready  (ready[k]),
      .in_work   (work[k]),
      .out_valid (valid[k+1]),
      .out_ready (ready[k+1]),
      .out_work  (work[k+1])
    );
  end

  c2p_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid[DEPTH]),
    .in_ready  (ready[DEPTH]),
    .in_work   (work[DEPTH]),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (result)
  );

endmodule
